### hw/rtl/charge_overcurrent_protect_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CHARGE_OVERCURRENT_PROTECT_ASSERT_SVH
`define CHARGE_OVERCURRENT_PROTECT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define COP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charge_overcurrent_protect: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define COP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charge_overcurrent_protect: assertion failed");

`endif

### hw/rtl/cop_pkg.sv
package cop_pkg;

    // Number of protection levels supported by the register map.
    localparam int CFG_REGS   = 3;
    localparam int LEVELS_DEF = 3;

    // APB register map: one 64-bit word per level at an 8-byte stride.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 2;
    localparam int REG_LSB   = 3;
    localparam int PARAMS_W  = 48;

    // Payload widths.
    localparam int LEVEL_W  = 2;
    localparam int MA_W     = 32;
    localparam int AMPS_W   = 22;
    localparam int STATES_W = 6;
    localparam int THRESH_W = 16;
    localparam int TICK_W   = 8;

    // Division by 1000 as a multiply by a rounded-up reciprocal and a shift.
    // The rounding error (56) stays below 2^(RECIP_SHIFT-MA_W), so the result
    // is the exact floor for every 32-bit magnitude.
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] MA_RECIP = RECIP_W'(274877907);

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_SETTING   = 2'd1,
        ST_TRIPPED   = 2'd2,
        ST_RELEASING = 2'd3
    } lvl_state_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TRIP    = 2'd1,
        EV_RELEASE = 2'd2
    } ev_kind_t;

    // Packed per-level configuration word, same layout as the register.
    typedef struct packed {
        logic [THRESH_W-1:0] set_amps;
        logic [TICK_W-1:0]   set_time;
        logic [THRESH_W-1:0] rel_amps;
        logic [TICK_W-1:0]   rel_time;
    } lvl_params_t;

    // One check after conversion to whole amps.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [AMPS_W-1:0]  amps;
    } amps_item_t;

endpackage

### hw/rtl/cop_check_if.sv
interface cop_check_if import cop_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [LEVEL_W-1:0]     level;
    logic signed [MA_W-1:0] current_ma;
    logic                   charging;

    modport source (output valid, level, current_ma, charging, input ready);
    modport sink   (input valid, level, current_ma, charging, output ready);

endinterface

### hw/rtl/cop_event_if.sv
interface cop_event_if import cop_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [1:0]          event_kind;
    logic [LEVEL_W-1:0]  event_level;
    logic [AMPS_W-1:0]   event_amps;
    logic [STATES_W-1:0] level_states;

    modport source (output valid, event_kind, event_level, event_amps, level_states,
                    input ready);
    modport sink   (input valid, event_kind, event_level, event_amps, level_states,
                    output ready);

endinterface

### hw/rtl/charge_overcurrent_protect.sv
// Charge overcurrent protection with debounce and hysteresis. Each transfer on
// check_in is one protection check for one level; each produces exactly one
// transfer on event_out, after passing the input, amps and output registers.
// One check is accepted every clock cycle unless event_out stalls: the path is
// a three-stage pipeline (input register, reciprocal multiply from milliamps
// to whole amps, then the per-level state update into the output register),
// and a stalled output only holds back the stages behind it once they fill.
// Level state and tick counters live in flip-flops and are updated in the last
// stage, so checks on the same level may follow each other back to back. The
// per-level thresholds and times sit in 64-bit APB registers at byte addresses
// 0, 8 and 16; write them only while no check is in flight.
module charge_overcurrent_protect import cop_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    cop_check_if.sink          check_in,
    cop_event_if.source        event_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    lvl_params_t params [CFG_REGS];
    logic        amps_valid;
    logic        amps_ready;
    amps_item_t  amps_item;

    // Configuration registers.
    cop_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .params  (params)
    );

    // Current conversion pipeline.
    cop_amps u_amps (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_in   (check_in),
        .amps_valid (amps_valid),
        .amps_ready (amps_ready),
        .amps_item  (amps_item)
    );

    // Level state machines and result register.
    cop_prot #(
        .LEVELS (LEVELS)
    ) u_prot (
        .clk        (clk),
        .rst_n      (rst_n),
        .amps_valid (amps_valid),
        .amps_ready (amps_ready),
        .amps_item  (amps_item),
        .params     (params),
        .event_out  (event_out)
    );

endmodule

### hw/rtl/cop_cfg_regs.sv
module cop_cfg_regs import cop_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output lvl_params_t        params [CFG_REGS]
);

    logic [PARAMS_W-1:0]  params_reg [CFG_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // The bus never waits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; an address beyond the last level is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                params_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                if (reg_idx == REG_IDX_W'(i))
                begin
                    params_reg[i] <= pwdata[PARAMS_W-1:0];
                end
            end
        end
    end

    // Read mux; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < CFG_REGS; i++)
        begin
            if (reg_idx == REG_IDX_W'(i))
            begin
                prdata = PDATA_W'(params_reg[i]);
            end
        end
    end

    // Present each word as its field view.
    always_comb
    begin
        for (int i = 0; i < CFG_REGS; i++)
        begin
            params[i] = lvl_params_t'(params_reg[i]);
        end
    end

endmodule

### hw/rtl/cop_amps.sv
module cop_amps import cop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cop_check_if.sink   check_in,
    output logic        amps_valid,
    input  logic        amps_ready,
    output amps_item_t  amps_item
);

    localparam int PROD_W = MA_W + RECIP_W;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [LEVEL_W-1:0] s1_level_reg;
    logic [MA_W-1:0]    s1_mag_reg;
    logic [MA_W-1:0]    s1_mag_next;
    logic               s1_ready;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [LEVEL_W-1:0] s2_level_reg;
    logic [AMPS_W-1:0]  s2_amps_reg;
    logic [AMPS_W-1:0]  s2_amps_next;
    logic               s2_ready;

    logic [MA_W-1:0]    raw_ma;
    logic [PROD_W-1:0]  prod;

    // Each stage takes a new transfer when it is empty or its content moves on.
    assign s2_ready       = !s2_valid_reg || amps_ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    assign check_in.ready = s1_ready;

    // Magnitude of the signed current; zero outside charge mode.
    assign raw_ma      = check_in.current_ma;
    assign s1_mag_next = !check_in.charging ? '0 :
                         (raw_ma[MA_W-1] ? (~raw_ma + MA_W'(1)) : raw_ma);

    // Milliamps to whole amps by reciprocal multiply.
    assign prod         = PROD_W'(s1_mag_reg) * PROD_W'(MA_RECIP);
    assign s2_amps_next = prod[RECIP_SHIFT +: AMPS_W];

    assign s1_valid_next = s1_ready ? check_in.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg   : s2_valid_reg;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (check_in.valid && s1_ready)
        begin
            s1_level_reg <= check_in.level;
            s1_mag_reg   <= s1_mag_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_level_reg <= s1_level_reg;
            s2_amps_reg  <= s2_amps_next;
        end
    end

    assign amps_valid      = s2_valid_reg;
    assign amps_item.level = s2_level_reg;
    assign amps_item.amps  = s2_amps_reg;

endmodule

### hw/rtl/cop_prot.sv
module cop_prot import cop_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        amps_valid,
    output logic        amps_ready,
    input  amps_item_t  amps_item,
    input  lvl_params_t params [CFG_REGS],
    cop_event_if.source event_out
);

    lvl_state_t          state_reg  [LEVELS];
    lvl_state_t          state_next [LEVELS];
    logic [TICK_W-1:0]   set_cnt_reg  [LEVELS];
    logic [TICK_W-1:0]   set_cnt_next [LEVELS];
    logic [TICK_W-1:0]   rel_cnt_reg  [LEVELS];
    logic [TICK_W-1:0]   rel_cnt_next [LEVELS];

    logic                out_valid_reg;
    ev_kind_t            out_kind_reg;
    ev_kind_t            out_kind_next;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [AMPS_W-1:0]   out_amps_reg;
    logic [STATES_W-1:0] out_states_reg;
    logic [STATES_W-1:0] out_states_next;

    logic                fire;
    lvl_state_t          st;
    ev_kind_t            kind;
    logic [TICK_W-1:0]   set_inc;
    logic [TICK_W-1:0]   rel_inc;
    logic [AMPS_W-1:0]   set_amps;
    logic [AMPS_W-1:0]   rel_amps;

    // The output register frees up when empty or when its transfer completes.
    assign amps_ready = !out_valid_reg || event_out.ready;
    assign fire       = amps_valid && amps_ready;

    // Per-level debounce: set check first, then release check on the updated state.
    always_comb
    begin
        out_kind_next   = EV_NONE;
        out_states_next = '0;
        st       = ST_IDLE;
        kind     = EV_NONE;
        set_inc  = '0;
        rel_inc  = '0;
        set_amps = '0;
        rel_amps = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            st              = state_reg[i];
            kind            = EV_NONE;
            set_cnt_next[i] = set_cnt_reg[i];
            rel_cnt_next[i] = rel_cnt_reg[i];
            set_inc         = set_cnt_reg[i] + TICK_W'(1);
            rel_inc         = rel_cnt_reg[i] + TICK_W'(1);
            set_amps        = AMPS_W'(params[i].set_amps);
            rel_amps        = AMPS_W'(params[i].rel_amps);

            if (fire && amps_item.level == LEVEL_W'(i))
            begin
                // Set check.
                if (amps_item.amps > set_amps)
                begin
                    if (st == ST_IDLE)
                    begin
                        st              = ST_SETTING;
                        set_cnt_next[i] = TICK_W'(1);
                    end
                    else if (st == ST_SETTING)
                    begin
                        set_cnt_next[i] = set_inc;
                        if (set_inc >= params[i].set_time)
                        begin
                            kind            = EV_TRIP;
                            st              = ST_TRIPPED;
                            set_cnt_next[i] = '0;
                        end
                    end
                end
                else if (st == ST_SETTING)
                begin
                    st = ST_IDLE;
                end

                // Release check.
                if (amps_item.amps < rel_amps)
                begin
                    if (st == ST_TRIPPED)
                    begin
                        st              = ST_RELEASING;
                        rel_cnt_next[i] = TICK_W'(1);
                    end
                    else if (st == ST_RELEASING)
                    begin
                        rel_cnt_next[i] = rel_inc;
                        if (rel_inc >= params[i].rel_time)
                        begin
                            kind            = EV_RELEASE;
                            st              = ST_IDLE;
                            rel_cnt_next[i] = '0;
                        end
                    end
                end
                else if (st == ST_RELEASING)
                begin
                    st = ST_TRIPPED;
                end

                out_kind_next = kind;
            end

            state_next[i]            = st;
            out_states_next[2*i +: 2] = st;
        end
    end

    // Level state and tick counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                state_reg[i]   <= ST_IDLE;
                set_cnt_reg[i] <= '0;
                rel_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                state_reg[i]   <= state_next[i];
                set_cnt_reg[i] <= set_cnt_next[i];
                rel_cnt_reg[i] <= rel_cnt_next[i];
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (amps_ready)
        begin
            out_valid_reg <= amps_valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_kind_reg   <= out_kind_next;
            out_level_reg  <= amps_item.level;
            out_amps_reg   <= amps_item.amps;
            out_states_reg <= out_states_next;
        end
    end

    assign event_out.valid        = out_valid_reg;
    assign event_out.event_kind   = out_kind_reg;
    assign event_out.event_level  = out_level_reg;
    assign event_out.event_amps   = out_amps_reg;
    assign event_out.level_states = out_states_reg;

endmodule

### hw/rtl/cop_checker.sv
`include "charge_overcurrent_protect_assert.svh"

module cop_prop_checker import cop_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                ev_valid,
    input logic                ev_ready,
    input logic [1:0]          ev_kind,
    input logic [LEVEL_W-1:0]  ev_level,
    input logic [AMPS_W-1:0]   ev_amps,
    input logic [STATES_W-1:0] ev_states
);

    // A stalled result keeps its payload.
    `COP_ASSERT_NEXT(a_stall_hold, ev_valid && !ev_ready, ev_valid && $stable(ev_kind) && $stable(ev_level) && $stable(ev_amps) && $stable(ev_states))

    // Events only come from levels that exist.
    `COP_ASSERT_IMPLY(a_event_level, ev_valid && ev_kind != EV_NONE, int'(ev_level) < LEVELS)

    // After a trip the level is tripped or already releasing.
    `COP_ASSERT_IMPLY(a_trip_state, ev_valid && ev_kind == EV_TRIP, (ev_level == 2'd0 && ev_states[1]) || (ev_level == 2'd1 && ev_states[3]) || (ev_level == 2'd2 && ev_states[5]))

    // After a release the level is back to idle.
    `COP_ASSERT_IMPLY(a_release_state, ev_valid && ev_kind == EV_RELEASE, (ev_level == 2'd0 && ev_states[1:0] == ST_IDLE) || (ev_level == 2'd1 && ev_states[3:2] == ST_IDLE) || (ev_level == 2'd2 && ev_states[5:4] == ST_IDLE))

endmodule

bind charge_overcurrent_protect cop_prop_checker #(
    .LEVELS (LEVELS)
) u_cop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (event_out.valid),
    .ev_ready  (event_out.ready),
    .ev_kind   (event_out.event_kind),
    .ev_level  (event_out.event_level),
    .ev_amps   (event_out.event_amps),
    .ev_states (event_out.level_states)
);
